/* design/register_ack_deframer_top_assert.svh */
// Assertion macros shared by the deframer RTL files.
`ifndef REGISTER_ACK_DEFRAMER_TOP_ASSERT_SVH
`define REGISTER_ACK_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RAD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rad assertion failed");

// Next-cycle implication, checked outside reset.
`define RAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rad assertion failed");

`endif

/* design/rad_pkg.sv */
// Types and constants shared by the register acknowledge deframer.
package rad_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned ADDR_HI_W   = ADDR_W - BYTE_W;
  localparam int unsigned WRITE_FLAG_BIT = 7;

  // Header byte being collected.
  typedef enum logic [1:0] {
    HDR_ID   = 2'd0,
    HDR_CMD  = 2'd1,
    HDR_ADDR = 2'd2,
    HDR_SIZE = 2'd3
  } hdr_state_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ERROR = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   reg_address;
    logic [BYTE_W-1:0]   reg_data;
    logic [BYTE_W-1:0]   trans_id;
  } result_t;

  // Registered input beat handed to the parser.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } byte_beat_t;

  // Parser result beat handed to the output register.
  typedef struct packed {
    logic    vld;
    result_t res;
  } res_beat_t;

endpackage

/* design/rad_in_stage.sv */
// Input register for received bytes.
module rad_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rad_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                        take,
  output rad_pkg::byte_beat_t         beat
);

  logic                       vld_r;
  logic                       vld_nxt;
  logic [rad_pkg::BYTE_W-1:0] data_r;
  logic                       load;

  // Stall only while a held byte cannot be consumed this cycle.
  assign in_stall = vld_r & ~take;
  assign load     = ~in_stall;
  assign vld_nxt  = load ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      data_r <= in_rx_byte;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

/* design/rad_parser.sv */
// Header collector and data byte sequencer.
`include "register_ack_deframer_top_assert.svh"

module rad_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rad_pkg::byte_beat_t  beat,
  input  logic                 out_ready,
  output logic                 take,
  output rad_pkg::res_beat_t   res_beat
);

  rad_pkg::hdr_state_t           state_r, state_nxt;
  logic [rad_pkg::BYTE_W-1:0]    id_r, id_nxt;
  logic [rad_pkg::BYTE_W-1:0]    cmd_r, cmd_nxt;
  logic [rad_pkg::ADDR_W-1:0]    base_r, base_nxt;
  logic [rad_pkg::BYTE_W-1:0]    left_r, left_nxt;
  logic [rad_pkg::BYTE_W-1:0]    offset_r, offset_nxt;
  logic                          has_data;

  assign has_data = (left_r != '0);

  always_comb begin
    state_nxt  = state_r;
    id_nxt     = id_r;
    cmd_nxt    = cmd_r;
    base_nxt   = base_r;
    left_nxt   = left_r;
    offset_nxt = offset_r;
    res_beat.vld             = 1'b0;
    res_beat.res.kind        = rad_pkg::KIND_WRITE;
    res_beat.res.reg_address = '0;
    res_beat.res.reg_data    = '0;
    res_beat.res.trans_id    = id_r;

    if (has_data) begin
      // Data phase: every byte is a register write.
      res_beat.vld             = beat.vld;
      res_beat.res.reg_address = base_r + {{rad_pkg::ADDR_HI_W{1'b0}}, offset_r};
      res_beat.res.reg_data    = beat.data;
      offset_nxt               = offset_r + 8'd1;
      left_nxt                 = left_r - 8'd1;
    end else begin
      case (state_r)
        rad_pkg::HDR_ID: begin
          id_nxt    = beat.data;
          state_nxt = rad_pkg::HDR_CMD;
        end
        rad_pkg::HDR_CMD: begin
          cmd_nxt   = beat.data;
          state_nxt = rad_pkg::HDR_ADDR;
        end
        rad_pkg::HDR_ADDR: begin
          base_nxt  = {cmd_r[rad_pkg::ADDR_HI_W-1:0], beat.data};
          state_nxt = rad_pkg::HDR_SIZE;
        end
        rad_pkg::HDR_SIZE: begin
          state_nxt  = rad_pkg::HDR_ID;
          offset_nxt = '0;
          if (cmd_r[rad_pkg::WRITE_FLAG_BIT]) begin
            // Write-flagged acknowledge: report and drop the size byte.
            left_nxt          = '0;
            res_beat.vld      = beat.vld;
            res_beat.res.kind = rad_pkg::KIND_ERROR;
          end else begin
            left_nxt = beat.data;
          end
        end
        default: begin
          state_nxt = rad_pkg::HDR_ID;
        end
      endcase
    end
  end

  assign take = beat.vld & (~res_beat.vld | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rad_pkg::HDR_ID;
      left_r   <= '0;
      offset_r <= '0;
    end else if (take) begin
      state_r  <= state_nxt;
      left_r   <= left_nxt;
      offset_r <= offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      id_r   <= id_nxt;
      cmd_r  <= cmd_nxt;
      base_r <= base_nxt;
    end
  end

  `RAD_ASSERT_IMPLY(a_err_only_on_size, clk, rst_n,
    res_beat.vld && res_beat.res.kind == rad_pkg::KIND_ERROR,
    state_r == rad_pkg::HDR_SIZE && left_r == '0)
  `RAD_ASSERT_NEXT(a_err_restarts_header, clk, rst_n,
    take && res_beat.vld && res_beat.res.kind == rad_pkg::KIND_ERROR,
    state_r == rad_pkg::HDR_ID && left_r == '0 && offset_r == '0)
  `RAD_ASSERT_NEXT(a_data_counts_down, clk, rst_n,
    take && left_r != '0,
    left_r == 8'($past(left_r) - 8'd1) && offset_r == 8'($past(offset_r) + 8'd1))
  `RAD_ASSERT_NEXT(a_header_holds_in_data, clk, rst_n,
    take && left_r != '0,
    state_r == $past(state_r))

endmodule

/* design/rad_out_stage.sv */
// Result register facing the output channel.
`include "register_ack_deframer_top_assert.svh"

module rad_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rad_pkg::res_beat_t                res_beat,
  input  logic                              take,
  output logic                              out_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic [rad_pkg::ADDR_W-1:0]        out_reg_address,
  output logic [rad_pkg::BYTE_W-1:0]        out_reg_data,
  output logic [rad_pkg::BYTE_W-1:0]        out_trans_id
);

  logic             vld_r;
  logic             vld_nxt;
  logic             load;
  rad_pkg::result_t res_r;

  // The register frees up when empty or when its beat leaves this cycle.
  assign out_ready = ~vld_r | ~out_stall;
  assign load      = take & res_beat.vld;
  assign vld_nxt   = out_ready ? load : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_beat.res;
    end
  end

  assign out_valid       = vld_r;
  assign out_kind        = res_r.kind;
  assign out_reg_address = res_r.reg_address;
  assign out_reg_data    = res_r.reg_data;
  assign out_trans_id    = res_r.trans_id;

  `RAD_ASSERT_IMPLY(a_load_needs_room, clk, rst_n, load, out_ready)
  `RAD_ASSERT_NEXT(a_stalled_result_held, clk, rst_n,
    vld_r && out_stall, vld_r && res_r == $past(res_r))
  `RAD_ASSERT_NEXT(a_load_shows_valid, clk, rst_n, load, vld_r)

endmodule

/* design/register_ack_deframer_top.sv */
// Top level of the register acknowledge deframer.
//
// Splits a received acknowledge byte stream into register writes. Each
// packet opens with four header bytes: transaction id, command (low six
// bits are address bits 13:8, bit 7 is the write flag), address bits 7:0
// and size. A read header with a nonzero size is followed by that many
// data bytes; each becomes one result with kind 0 at (address + offset)
// wrapping at 14 bits, tagged with the header's transaction id. A
// write-flagged header yields one result with kind 1, zero address and
// data, and its size byte is dropped. A zero-size read header and every
// other header byte yield no result. Throughput is one byte per clock
// while the output channel does not stall: a byte is held in the input
// register, parsed there in a single pass, and its result is loaded into
// the output register when the parser takes it. Stall on the output
// channel backs up through the output register into in_stall only when
// the held byte has a result and the output register is full and stalled.
module register_ack_deframer_top (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rad_pkg::BYTE_W-1:0]  in_rx_byte,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [rad_pkg::ADDR_W-1:0]  out_reg_address,
  output logic [rad_pkg::BYTE_W-1:0]  out_reg_data,
  output logic [rad_pkg::BYTE_W-1:0]  out_trans_id
);

  rad_pkg::byte_beat_t byte_beat;
  rad_pkg::res_beat_t  res_beat;
  logic                take;
  logic                out_ready;

  // Hold each accepted beat until the parser consumes it.
  rad_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .beat       (byte_beat)
  );

  // Advance the header / data sequence and form the result.
  rad_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (byte_beat),
    .out_ready (out_ready),
    .take      (take),
    .res_beat  (res_beat)
  );

  // Register results and drive the output channel.
  rad_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_beat        (res_beat),
    .take            (take),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_reg_address (out_reg_address),
    .out_reg_data    (out_reg_data),
    .out_trans_id    (out_trans_id)
  );

endmodule
